### hdl/timed_slot_pool_free_list_defines.svh
// assertion helpers for the timed slot pool
`ifndef TIMED_SLOT_POOL_FREE_LIST_DEFINES_SVH
`define TIMED_SLOT_POOL_FREE_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define TSPFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TSPFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TSPFL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSPFL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tspfl_pkg.sv
`default_nettype none

package tspfl_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int LINK_W    = SLOT_W + 1;
  localparam int TIMER_W   = 8;
  localparam int SCALE_W   = 16;
  localparam int MASK_W    = 8;
  localparam int GRANT_W   = 3;
  localparam int HEAD_W    = 4;
  localparam int IDX_W     = 3;
  localparam int OP_W      = 2;

  localparam logic [TIMER_W-1:0] LIFETIME_RESET = 8'd8;

  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [IDX_W-1:0]          slot_index;
    logic signed [SCALE_W-1:0] scale_value;
  } in_item_t;

  typedef struct packed {
    logic                     accepted;
    logic [GRANT_W-1:0]       granted_slot;
    logic [MASK_W-1:0]        released_mask;
    logic signed [HEAD_W-1:0] free_head;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              exec;
    logic              step;
    logic [SLOT_W-1:0] slot;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_is_tick;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/tspfl_datapath.sv
`default_nettype none

module tspfl_datapath
  import tspfl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctl_cmd_t            cmd,
  output dp_status_t               status,
  input  wire in_item_t            in_data,
  input  wire logic                cfg_valid,
  input  wire logic [TIMER_W-1:0]  cfg_data,
  output out_item_t                out_data
);

  logic [TIMER_W-1:0]        lifetime_r;
  logic [OP_W-1:0]           op_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [SCALE_W-1:0] scale_r;

  logic                      hidden_r [NUM_SLOTS];
  logic [TIMER_W-1:0]        timer_r  [NUM_SLOTS];
  logic signed [LINK_W-1:0]  link_r   [NUM_SLOTS];
  logic signed [SCALE_W-1:0] slot_scale_r [NUM_SLOTS];
  logic signed [LINK_W-1:0]  head_r;

  logic                      acc_r;
  logic [GRANT_W-1:0]        grant_r;
  logic [MASK_W-1:0]         mask_r;

  logic              head_ok;
  logic [SLOT_W-1:0] head_idx;
  logic              rel_ok;
  logic [SLOT_W-1:0] rel_idx;

  // a negative or out-of-range head means the list is empty
  assign head_idx = head_r[SLOT_W-1:0];
  assign head_ok  = !head_r[LINK_W-1] && (int'(head_idx) < NUM_SLOTS);
  assign rel_idx  = SLOT_W'(idx_r);
  assign rel_ok   = (int'(idx_r) < NUM_SLOTS) && !hidden_r[rel_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
      head_r     <= '0;
      acc_r      <= 1'b0;
      grant_r    <= '0;
      mask_r     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        hidden_r[i]     <= 1'b1;
        timer_r[i]      <= '0;
        slot_scale_r[i] <= '0;
        link_r[i]       <= (i + 1 < NUM_SLOTS) ? LINK_W'(i + 1) : '1;
      end
    end else begin
      if (cfg_valid) begin
        lifetime_r <= cfg_data;
      end
      if (cmd.capture) begin
        acc_r   <= 1'b0;
        grant_r <= '0;
        mask_r  <= '0;
      end else if (cmd.exec) begin
        case (op_r)
          OP_RELEASE: begin
            if (rel_ok) begin
              hidden_r[rel_idx] <= 1'b1;
              link_r[rel_idx]   <= head_r;
              head_r            <= {1'b0, rel_idx};
              acc_r             <= 1'b1;
              for (int j = 0; j < MASK_W; j++) begin
                if (int'(idx_r) == j) mask_r[j] <= 1'b1;
              end
            end
          end
          OP_ALLOCATE: begin
            if (head_ok) begin
              hidden_r[head_idx]     <= 1'b0;
              slot_scale_r[head_idx] <= scale_r;
              timer_r[head_idx]      <= lifetime_r;
              head_r                 <= link_r[head_idx];
              acc_r                  <= 1'b1;
              grant_r                <= GRANT_W'(head_idx);
            end
          end
          OP_TICK: begin
            acc_r <= 1'b1;
          end
          default: begin
            acc_r <= 1'b0;
          end
        endcase
      end else if (cmd.step) begin
        if (!hidden_r[cmd.slot]) begin
          if (timer_r[cmd.slot] > TIMER_W'(1)) begin
            timer_r[cmd.slot] <= timer_r[cmd.slot] - TIMER_W'(1);
          end else begin
            // expired: push back onto the free list
            hidden_r[cmd.slot] <= 1'b1;
            link_r[cmd.slot]   <= head_r;
            head_r             <= {1'b0, cmd.slot};
            for (int j = 0; j < MASK_W; j++) begin
              if (int'(cmd.slot) == j) mask_r[j] <= 1'b1;
            end
          end
        end
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.operation;
      idx_r   <= in_data.slot_index;
      scale_r <= in_data.scale_value;
    end
  end

  assign status.op_is_tick      = (op_r == OP_TICK);
  assign out_data.accepted      = acc_r;
  assign out_data.granted_slot  = grant_r;
  assign out_data.released_mask = mask_r;
  assign out_data.free_head     = HEAD_W'(head_r);

endmodule

`default_nettype wire

### hdl/tspfl_ctrl.sv
`default_nettype none

module tspfl_ctrl
  import tspfl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd,
  output logic            busy,
  output logic            out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_DONE
  } state_t;

  state_t            state_r;
  logic              busy_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          if (status.op_is_tick) begin
            state_r <= S_TICK;
            slot_r  <= SLOT_W'(NUM_SLOTS - 1);
          end else begin
            state_r     <= S_DONE;
            out_valid_r <= 1'b1;
          end
        end
        S_TICK: begin
          // walk from the highest slot down to slot zero
          if (slot_r == '0) begin
            state_r     <= S_DONE;
            out_valid_r <= 1'b1;
          end else begin
            slot_r <= slot_r - SLOT_W'(1);
          end
        end
        S_DONE: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
          busy_r      <= 1'b0;
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
          busy_r      <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.step    = (state_r == S_TICK);
  assign cmd.slot    = slot_r;
  assign busy        = busy_r;
  assign out_valid   = out_valid_r;

endmodule

`default_nettype wire

### hdl/timed_slot_pool_free_list.sv
// release, allocate and unused codes: captured on start, executed in S_EXEC,
// result strobe registered; tick: S_TICK visits one slot per cycle, then strobes
// next item taken only back in S_IDLE, after S_DONE; busy covers the result
// the result strobe lasts one cycle and the receiver cannot stall it
// synchronous active-low reset: all slots hidden, linked in ascending order, head 0
// lifetime resets to 8; config is always ready
`default_nettype none

`include "timed_slot_pool_free_list_defines.svh"

module timed_slot_pool_free_list
  import tspfl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [TIMER_W-1:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tspfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tspfl_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  `TSPFL_ASSERT_IMP(a_valid_while_busy, clk, rst_n, out_valid, busy)
  `TSPFL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
  `TSPFL_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid && !busy)
  `TSPFL_ASSERT_IMP(a_grant_accepted, clk, rst_n, out_valid && out_data.granted_slot != '0, out_data.accepted)

endmodule

`default_nettype wire

### tb/timed_slot_pool_free_list_tb.sv
`timescale 1ns / 1ps

module timed_slot_pool_free_list_tb;
  import tspfl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 200000;
  localparam int PHASE_ITEMS = 93;

  typedef struct {
    bit                 is_cfg;
    logic [TIMER_W-1:0] lifetime;
    in_item_t           item;
    bit                 has_fixed;
    out_item_t          fixed;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_item_t           in_data = '0;
  logic               out_valid;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TIMER_W-1:0] cfg_data = '0;

  // pool as the testbench sees it
  logic [TIMER_W-1:0] pool_lifetime;
  logic [NUM_SLOTS-1:0] pool_hidden;
  logic [TIMER_W-1:0] pool_timer [NUM_SLOTS];
  int                 pool_link [NUM_SLOTS];
  logic [SCALE_W-1:0] pool_scale [NUM_SLOTS];
  int                 pool_head;

  out_item_t          pending_replies [$];
  out_item_t          reply_due;
  plan_row_t          plan [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  timed_slot_pool_free_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic in_item_t make_item(input logic [OP_W-1:0] op, input int idx,
                                         input int scale);
    in_item_t it;
    it.operation   = op;
    it.slot_index  = idx[IDX_W-1:0];
    it.scale_value = scale[SCALE_W-1:0];
    return it;
  endfunction

  function automatic plan_row_t item_row(input logic [OP_W-1:0] op, input int idx,
                                         input int scale);
    plan_row_t r;
    r = '{default: '0};
    r.item = make_item(op, idx, scale);
    return r;
  endfunction

  function automatic plan_row_t fixed_row(input logic [OP_W-1:0] op, input int idx,
                                          input int scale, input logic acc,
                                          input int grant, input int mask,
                                          input int head);
    plan_row_t r;
    r = item_row(op, idx, scale);
    r.has_fixed = 1'b1;
    r.fixed.accepted      = acc;
    r.fixed.granted_slot  = grant[GRANT_W-1:0];
    r.fixed.released_mask = mask[MASK_W-1:0];
    r.fixed.free_head     = head[HEAD_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t lifetime_row(input logic [TIMER_W-1:0] v);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg   = 1'b1;
    r.lifetime = v;
    return r;
  endfunction

  function automatic void push_free(input int s);
    pool_hidden[s] = 1'b1;
    pool_link[s]   = pool_head;
    pool_head      = s;
  endfunction

  function automatic out_item_t apply_to_pool(input in_item_t it);
    out_item_t r;
    int h;
    int s;
    r = '0;
    case (it.operation)
      OP_RELEASE: begin
        s = int'(it.slot_index);
        if (s < NUM_SLOTS && !pool_hidden[s]) begin
          push_free(s);
          r.accepted = 1'b1;
          r.released_mask[s] = 1'b1;
        end
      end
      OP_ALLOCATE: begin
        h = pool_head;
        // a head outside the pool reads as an empty list
        if (h >= 0 && h < NUM_SLOTS) begin
          pool_hidden[h] = 1'b0;
          pool_scale[h]  = it.scale_value;
          pool_timer[h]  = pool_lifetime;
          pool_head      = pool_link[h];
          r.accepted     = 1'b1;
          r.granted_slot = h[GRANT_W-1:0];
        end
      end
      OP_TICK: begin
        r.accepted = 1'b1;
        for (s = NUM_SLOTS - 1; s >= 0; s--) begin
          if (!pool_hidden[s]) begin
            if (pool_timer[s] > 1) begin
              pool_timer[s] = pool_timer[s] - 1'b1;
            end else begin
              push_free(s);
              if (s < MASK_W) r.released_mask[s] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.free_head = pool_head[HEAD_W-1:0];
    return r;
  endfunction

  // mostly releases of live slots and allocates, so leases actually run out
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    int live [$];
    int s;
    r  = $urandom_range(0, 99);
    it = make_item(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 65535));
    if (r < 38) begin
      it.operation = OP_ALLOCATE;
    end else if (r < 72) begin
      it.operation = OP_RELEASE;
      for (s = 0; s < NUM_SLOTS; s++) if (!pool_hidden[s]) live.push_back(s);
      if (live.size() != 0 && $urandom_range(0, 9) < 7)
        it.slot_index = IDX_W'(live[$urandom_range(0, live.size() - 1)]);
    end else if (r >= 95) begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  // leaves start high on return; the caller lowers it or sends again
  task automatic send_item(input in_item_t it, input bit has_fixed, input out_item_t fixed);
    out_item_t predicted;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predicted = apply_to_pool(it);
    pending_replies.push_back(has_fixed ? fixed : predicted);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [TIMER_W-1:0] v);
    drain_replies();
    repeat (NUM_SLOTS + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    pool_lifetime = v;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("result strobe with nothing expected");
        mismatch_count++;
      end else begin
        reply_due = pending_replies.pop_front();
        if (out_data.accepted !== reply_due.accepted) begin
          $error("accepted expected %0d got %0d", reply_due.accepted, out_data.accepted);
          mismatch_count++;
        end
        if (out_data.granted_slot !== reply_due.granted_slot) begin
          $error("granted_slot expected %0d got %0d", reply_due.granted_slot,
                 out_data.granted_slot);
          mismatch_count++;
        end
        if (out_data.released_mask !== reply_due.released_mask) begin
          $error("released_mask expected %h got %h", reply_due.released_mask,
                 out_data.released_mask);
          mismatch_count++;
        end
        if (out_data.free_head !== reply_due.free_head) begin
          $error("free_head expected %0d got %0d", reply_due.free_head, out_data.free_head);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("[timed_slot_pool_free_list] ERROR");
      $finish;
    end
  end

  initial begin
    logic [TIMER_W-1:0] lifetimes [7];
    int p;
    int k;
    int sent;
    int burst;
    bit paused;

    pool_lifetime = LIFETIME_RESET;
    pool_hidden   = '1;
    pool_head     = 0;
    for (k = 0; k < NUM_SLOTS; k++) begin
      pool_timer[k] = '0;
      pool_scale[k] = '0;
      pool_link[k]  = (k + 1 < NUM_SLOTS) ? k + 1 : -1;
    end

    // everything hidden after reset: release, unused code and tick do nothing
    plan.push_back(fixed_row(OP_RELEASE, 3, 0, 1'b0, 0, 0, 0));
    plan.push_back(fixed_row(OP_UNUSED, 7, 16'hffff, 1'b0, 0, 0, 0));
    plan.push_back(fixed_row(OP_TICK, 0, 0, 1'b1, 0, 0, 0));
    plan.push_back(fixed_row(OP_ALLOCATE, 0, -32768, 1'b1, 0, 0, 1));
    plan.push_back(fixed_row(OP_ALLOCATE, 7, 32767, 1'b1, 1, 0, 2));
    plan.push_back(fixed_row(OP_RELEASE, 0, 0, 1'b1, 0, 8'h01, 0));
    // second release of a hidden slot
    plan.push_back(fixed_row(OP_RELEASE, 0, 0, 1'b0, 0, 0, 0));
    plan.push_back(item_row(OP_ALLOCATE, 5, 16'h5555));
    plan.push_back(item_row(OP_ALLOCATE, 2, 16'haaaa));
    plan.push_back(item_row(OP_ALLOCATE, 1, 16'h0001));
    plan.push_back(item_row(OP_ALLOCATE, 6, 16'h8001));
    plan.push_back(item_row(OP_ALLOCATE, 3, 16'h7ffe));
    plan.push_back(item_row(OP_ALLOCATE, 4, 16'hffff));
    plan.push_back(item_row(OP_ALLOCATE, 0, 0));
    // empty list
    plan.push_back(fixed_row(OP_ALLOCATE, 7, 16'h1234, 1'b0, 0, 0, -1));
    plan.push_back(lifetime_row(8'd1));
    plan.push_back(fixed_row(OP_RELEASE, 7, 0, 1'b1, 0, 8'h80, 7));
    plan.push_back(item_row(OP_ALLOCATE, 0, 16'h00ff));
    plan.push_back(item_row(OP_TICK, 0, 0));
    // lifetime zero expires on the next tick
    plan.push_back(lifetime_row(8'd0));
    plan.push_back(item_row(OP_RELEASE, 6, 0));
    plan.push_back(item_row(OP_ALLOCATE, 0, 16'hff00));
    plan.push_back(item_row(OP_TICK, 5, 0));
    plan.push_back(lifetime_row(8'd255));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        write_lifetime(plan[k].lifetime);
      end else begin
        send_item(plan[k].item, plan[k].has_fixed, plan[k].fixed);
        idle_gap($urandom_range(0, 3));
      end
    end

    lifetimes = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd2, 8'd5, 8'd8};
    lifetimes[6] = TIMER_W'($urandom_range(1, 254));
    paused = 1'b0;
    for (p = 0; p < 7; p++) begin
      write_lifetime(lifetimes[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          send_item(random_item(), 1'b0, '0);
          sent++;
        end
        if (p == 1 && !paused && sent >= 40) begin
          drain_replies();
          paused = 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
          idle_gap(0);
        end else begin
          idle_gap($urandom_range(1, 12));
        end
      end
    end

    drain_replies();
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[timed_slot_pool_free_list] OK");
    end else begin
      $display("[timed_slot_pool_free_list] ERROR");
    end
    $finish;
  end

endmodule
